>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL, clocked and reset-gated.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle assertion failed");

`endif

>>> rtl/ssll_pkg.sv
// ---------------------------------------------------------------------------
// ssll_pkg
// Types and codes shared by the sorted list cells and the top level.
// ---------------------------------------------------------------------------
package ssll_pkg;

	localparam int KEY_W  = 32;
	localparam int AGE_W  = 8;
	localparam int KIND_W = 2;
	localparam int MODE_W = 2;
	localparam int CNT_OUT_W = 7;

	// operation kinds
	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CHANGE = 2'd2;

	// token modes while it travels the chain
	localparam logic [MODE_W-1:0] MODE_SEARCH  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SHIFT_R = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SHIFT_L = 2'd2;
	localparam logic [MODE_W-1:0] MODE_PASS    = 2'd3;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [AGE_W-1:0] age;
	} entry_t;

	typedef struct packed {
		logic              active;
		logic [MODE_W-1:0] mode;
		logic              ok;
		entry_t            carry;
	} token_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [KEY_W-1:0]  key;
		logic [KEY_W-1:0]  new_key;
		logic [AGE_W-1:0]  age;
	} cmd_t;

endpackage

>>> rtl/ssll_cell.sv
// ---------------------------------------------------------------------------
// ssll_cell
// One record slot of the ordered chain; processes the passing token.
// ---------------------------------------------------------------------------
module ssll_cell import ssll_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   step,   // advance the chain
	input  cmd_t   cmd,    // operation being walked, held for the whole pass
	input  token_t tin,    // token from the left neighbor
	input  entry_t nb,     // content of the right neighbor
	output entry_t ent,
	output token_t tout
);

	logic             val_q;
	logic [KEY_W-1:0] key_q;
	logic [AGE_W-1:0] age_q;
	token_t           tok_q;

	entry_t ent_cur;
	entry_t ent_d;
	token_t tok_d;
	logic   less;
	logic   found;

	assign ent_cur = '{valid: val_q, key: key_q, age: age_q};
	assign less    = $signed(key_q) < $signed(cmd.key);
	assign found   = val_q && (key_q == cmd.key);

	always_comb begin
		ent_d = ent_cur;
		tok_d = tin;
		if (tin.active) begin
			unique case (tin.mode)
				MODE_SEARCH: begin
					if (!(val_q && less)) begin
						// stop node reached
						tok_d.mode = MODE_PASS;
						tok_d.ok   = 1'b0;
						unique case (cmd.kind)
							KIND_INSERT: begin
								if (!found) begin
									ent_d       = '{valid: 1'b1, key: cmd.key, age: cmd.age};
									tok_d.carry = ent_cur;
									tok_d.mode  = MODE_SHIFT_R;
									tok_d.ok    = 1'b1;
								end
							end
							KIND_DELETE: begin
								if (found) begin
									ent_d      = nb;
									tok_d.mode = MODE_SHIFT_L;
									tok_d.ok   = 1'b1;
								end
							end
							KIND_CHANGE: begin
								if (found) begin
									ent_d.key = cmd.new_key;
									tok_d.ok  = 1'b1;
								end
							end
							default: begin
								tok_d.ok = 1'b0;
							end
						endcase
					end
				end
				MODE_SHIFT_R: begin
					// swap held record with the carried one
					ent_d       = tin.carry;
					tok_d.carry = ent_cur;
				end
				MODE_SHIFT_L: begin
					ent_d = nb;
				end
				MODE_PASS: begin
					ent_d = ent_cur;
				end
				default: begin
					ent_d = ent_cur;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= 1'b0;
			tok_q <= '0;
		end else if (step) begin
			val_q <= ent_d.valid;
			tok_q <= tok_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			key_q <= ent_d.key;
			age_q <= ent_d.age;
		end
	end

	assign ent  = ent_cur;
	assign tout = tok_q;

endmodule

>>> rtl/sorted_static_linked_list.sv
// ---------------------------------------------------------------------------
// sorted_static_linked_list
// Key-ordered record pool with insert, delete and in-place key change.
// ---------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_tvalid/s_tready with the operation kind on s_tuser
//   (insert, delete, change key in place) and key, new key and age on s_tdata.
//   Each input word gives exactly one result word on m_tvalid/m_tready: success
//   flag, record count after the operation, full and empty flags.
//   Records sit in a row of ENTRIES cells in ascending list order. One token
//   per operation enters cell 0 and moves one cell per cycle unless the row is
//   frozen; it searches for the first record whose key is not below the given
//   key, then commits the operation there and ripples the shift of later records.
//   Every token crosses the whole row before its result is presented, and a
//   new word is taken the cycle after the result leaves the chain, so only one
//   word is walked through the row at a time.
//   Reset empties the list (count 0, all cells invalid) and clears both channels.
//   When the receiver stalls, the result waits in the output register; a
//   following operation may already be taken and walked, and the row holds
//   its token at the last cell until the output register frees.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_static_linked_list import ssll_pkg::*; #(
	parameter int ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // key[31:0], new_key[63:32], age[71:64]
	input  logic [1:0]  s_tuser,  // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // ok[0], count[7:1], full_res[8], empty_res[9], zero pad
);

	localparam int CNT_W = $clog2(ENTRIES + 1);

	logic             busy_q;
	logic             launch_q;
	cmd_t             cmd_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;
	logic             mvalid_q;
	logic [9:0]       mdata_q;

	token_t launch_tok;
	token_t tin  [ENTRIES];
	token_t tok  [ENTRIES];
	entry_t ent  [ENTRIES];
	entry_t nb   [ENTRIES];
	logic [ENTRIES-1:0] act_vec;

	logic step;
	logic exit_fire;
	logic s_fire;
	logic full_now;
	logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;
	token_t last_tok;

	assign s_tready  = !busy_q;
	assign s_fire    = s_tvalid && s_tready;
	assign last_tok  = tok[ENTRIES-1];
	// freeze the row while a finished result cannot leave
	assign step      = !(last_tok.active && mvalid_q && !m_tready);
	assign exit_fire = last_tok.active && step;
	assign full_now  = (cnt_q == CNT_W'(ENTRIES));

	// launch token: search unless the operation cannot succeed at all
	always_comb begin
		launch_tok        = '0;
		launch_tok.active = launch_q;
		launch_tok.mode   = MODE_PASS;
		unique case (cmd_q.kind)
			KIND_INSERT: begin
				if (!full_now) begin
					launch_tok.mode = MODE_SEARCH;
				end
			end
			KIND_DELETE: begin
				launch_tok.mode = MODE_SEARCH;
			end
			KIND_CHANGE: begin
				launch_tok.mode = MODE_SEARCH;
			end
			default: begin
				launch_tok.mode = MODE_PASS;
			end
		endcase
	end

	genvar i;
	generate
		for (i = 0; i < ENTRIES; i++) begin : g_cell
			if (i == 0) begin : g_first
				assign tin[i] = launch_tok;
			end else begin : g_mid
				assign tin[i] = tok[i-1];
			end
			if (i == ENTRIES - 1) begin : g_end
				assign nb[i] = '0;
			end else begin : g_inner
				assign nb[i] = ent[i+1];
			end
			assign act_vec[i] = tok[i].active;

			ssll_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.step   (step),
				.cmd    (cmd_q),
				.tin    (tin[i]),
				.nb     (nb[i]),
				.ent    (ent[i]),
				.tout   (tok[i])
			);
		end
	endgenerate

	// count after the finishing operation
	always_comb begin
		cnt_d = cnt_q;
		if (last_tok.ok && cmd_q.kind == KIND_INSERT) begin
			cnt_d = cnt_q + CNT_W'(1);
		end else if (last_tok.ok && cmd_q.kind == KIND_DELETE) begin
			cnt_d = cnt_q - CNT_W'(1);
		end
	end

	assign cnt_ext = {{CNT_OUT_W{1'b0}}, cnt_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			launch_q <= 1'b0;
			cnt_q    <= '0;
			mvalid_q <= 1'b0;
		end else begin
			if (s_fire) begin
				busy_q   <= 1'b1;
				launch_q <= 1'b1;
			end else begin
				if (step) begin
					launch_q <= 1'b0;
				end
				if (exit_fire) begin
					busy_q <= 1'b0;
				end
			end
			if (exit_fire) begin
				cnt_q    <= cnt_d;
				mvalid_q <= 1'b1;
			end else if (m_tready) begin
				mvalid_q <= 1'b0;
			end
		end
	end

	// hold the operation for the whole pass; latch the result word
	always_ff @(posedge clk) begin
		if (s_fire) begin
			cmd_q.kind    <= s_tuser;
			cmd_q.key     <= s_tdata[31:0];
			cmd_q.new_key <= s_tdata[63:32];
			cmd_q.age     <= s_tdata[71:64];
		end
		if (exit_fire) begin
			mdata_q <= {(cnt_d == '0), (cnt_d == CNT_W'(ENTRIES)),
				cnt_ext[CNT_OUT_W-1:0], last_tok.ok};
		end
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata  = {6'b0, mdata_q};

	// at most one operation walks the row
	`ASSERT_IMPLY(a_one_token, clk, arst_n, 1'b1, $onehot0(act_vec))
	// a token only exists while an operation is outstanding
	`ASSERT_IMPLY(a_token_busy, clk, arst_n, act_vec != '0, busy_q)
	// an accepted word is launched next cycle, with no token left in the row
	`ASSERT_NEXT(a_launch, clk, arst_n, s_fire, launch_q && act_vec == '0)
	// record count stays within the pool
	`ASSERT_IMPLY(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= CNT_W'(ENTRIES))

endmodule

>>> test/tb_sorted_static_linked_list.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_sorted_static_linked_list
// Self-checking bench for the key-ordered record pool. A behavioral copy of
// the node pool, the record list and the free list predicts the status word
// of every operation word. Each status word leaving the block is compared,
// field by field, with the oldest prediction. Directed words cover edge keys
// and failure cases first. Random fill and drain sweeps then follow, under
// three idle patterns on the two channels.
// ---------------------------------------------------------------------------
module tb_sorted_static_linked_list;
	import ssll_pkg::*;

	localparam int POOL      = 64;
	localparam int NULL_LINK = POOL;
	localparam int PHASE_WORDS = 643;

	// kind code the block must reject
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	localparam logic [KEY_W-1:0] KEY_MIN  = 32'h8000_0000;
	localparam logic [KEY_W-1:0] KEY_MAX  = 32'h7FFF_FFFF;
	localparam logic [KEY_W-1:0] KEY_NEG1 = 32'hFFFF_FFFF;

	typedef struct packed {
		logic                 ok;
		logic [CNT_OUT_W-1:0] count;
		logic                 full_res;
		logic                 empty_res;
	} list_status_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata  = '0;  // key[31:0], new_key[63:32], age[71:64]
	logic [1:0]  s_tuser  = '0;  // kind[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // ok[0], count[7:1], full_res[8], empty_res[9], zero pad

	// idle chance per cycle, in percent, for the sender and the receiver
	int src_idle_pct = 0;
	int snk_idle_pct = 0;

	// predicted pool: keys, ages and links of every node, plus both list heads
	logic [KEY_W-1:0] slot_key [POOL];
	logic [AGE_W-1:0] slot_age [POOL];
	int               slot_next [POOL];
	int               list_first;
	int               free_first;
	int               records;

	list_status_t     expected_status_q [$];
	logic [KEY_W-1:0] live_keys [$];

	int mismatches  = 0;
	int words_seen  = 0;
	int ok_total    = 0;
	int full_hits   = 0;
	int empty_hits  = 0;
	int kind_sent [4] = '{0, 0, 0, 0};

	sorted_static_linked_list #(
		.ENTRIES(POOL)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// list predictor
	// ------------------------------------------------------------------

	// empty list, every node chained on the free list in index order
	function automatic void clear_pool_model();
		for (int n = 0; n < POOL; n++) begin
			slot_key[n]  = '0;
			slot_age[n]  = '0;
			slot_next[n] = n + 1;
		end
		list_first = NULL_LINK;
		free_first = 0;
		records    = 0;
	endfunction

	// follow a link; anything out of range reads as the end of a list
	function automatic int follow(input int n);
		if (n >= POOL)
			return NULL_LINK;
		return (slot_next[n] >= POOL) ? NULL_LINK : slot_next[n];
	endfunction

	// advance past every node whose key is below k; give up after POOL steps
	function automatic int locate(input logic [KEY_W-1:0] k, output int prev);
		int cur;
		int steps;
		cur   = (list_first >= POOL) ? NULL_LINK : list_first;
		steps = 0;
		prev  = NULL_LINK;
		while (cur < POOL && steps < POOL && $signed(slot_key[cur]) < $signed(k)) begin
			prev = cur;
			cur  = follow(cur);
			steps++;
		end
		if (steps >= POOL)
			cur = NULL_LINK;
		return cur;
	endfunction

	function automatic list_status_t apply_list_op(input logic [KIND_W-1:0] kind,
			input logic [KEY_W-1:0] key, input logic [KEY_W-1:0] nkey,
			input logic [AGE_W-1:0] age);
		int           prev;
		int           cur;
		int           nn;
		logic         ok;
		list_status_t st;
		ok = 1'b0;
		case (kind)
			KIND_INSERT: begin
				// a full pool or a key already at the stop node leaves all unchanged
				if (free_first < POOL) begin
					cur = locate(key, prev);
					if (!(cur < POOL && slot_key[cur] == key)) begin
						nn         = free_first;
						free_first = follow(nn);
						slot_key[nn] = key;
						slot_age[nn] = age;
						if (prev >= POOL) begin
							slot_next[nn] = (list_first >= POOL) ? NULL_LINK : list_first;
							list_first    = nn;
						end else begin
							slot_next[nn]   = follow(prev);
							slot_next[prev] = nn;
						end
						if (records < POOL)
							records++;
						ok = 1'b1;
					end
				end
			end
			KIND_DELETE: begin
				cur = locate(key, prev);
				if (cur < POOL && slot_key[cur] == key) begin
					if (prev >= POOL)
						list_first = follow(cur);
					else
						slot_next[prev] = follow(cur);
					slot_next[cur] = (free_first >= POOL) ? NULL_LINK : free_first;
					free_first     = cur;
					if (records > 0)
						records--;
					ok = 1'b1;
				end
			end
			KIND_CHANGE: begin
				// rewrite in place: no check of order or duplicates
				cur = locate(key, prev);
				if (cur < POOL && slot_key[cur] == key) begin
					slot_key[cur] = nkey;
					ok = 1'b1;
				end
			end
			default: begin
			end
		endcase
		st.ok        = ok;
		st.count     = records[CNT_OUT_W-1:0];
		st.full_res  = (records == POOL);
		st.empty_res = (records == 0);
		return st;
	endfunction

	// snapshot the keys currently linked, in list order
	function automatic void refresh_live_keys();
		int cur;
		int steps;
		live_keys.delete();
		cur   = (list_first >= POOL) ? NULL_LINK : list_first;
		steps = 0;
		while (cur < POOL && steps < POOL) begin
			live_keys.push_back(slot_key[cur]);
			cur = follow(cur);
			steps++;
		end
	endfunction

	// often a narrow band around zero so duplicates happen, else wide or edge keys
	function automatic logic [KEY_W-1:0] random_key();
		logic [KEY_W-1:0] v;
		int               pick;
		pick = $urandom_range(99);
		if (pick < 45) begin
			v = $urandom_range(80);
			v = v - 32'd40;
		end else if (pick < 85) begin
			v = $urandom;
		end else begin
			case ($urandom_range(5))
				0: v = KEY_MIN;
				1: v = KEY_MAX;
				2: v = KEY_NEG1;
				3: v = KEY_MIN + 32'd1;
				4: v = KEY_MAX - 32'd1;
				default: v = '0;
			endcase
		end
		return v;
	endfunction

	// ------------------------------------------------------------------
	// sender: present one operation word, hold it until taken, then predict
	// ------------------------------------------------------------------
	task automatic send_word(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
			input logic [KEY_W-1:0] nkey, input logic [AGE_W-1:0] age);
		list_status_t st;
		if ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < src_idle_pct)
				@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {age, nkey, key};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		st = apply_list_op(kind, key, nkey, age);
		expected_status_q.push_back(st);
		kind_sent[kind]++;
		if (st.ok) begin
			ok_total++;
			if (kind == KIND_INSERT && st.full_res)
				full_hits++;
			if (kind == KIND_DELETE && st.empty_res)
				empty_hits++;
		end
	endtask

	// ------------------------------------------------------------------
	// receiver: random back-pressure, then check every status word taken
	// ------------------------------------------------------------------
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= snk_idle_pct);

	always @(posedge clk) begin
		list_status_t got;
		list_status_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.ok        = m_tdata[0];
			got.count     = m_tdata[7:1];
			got.full_res  = m_tdata[8];
			got.empty_res = m_tdata[9];
			words_seen++;
			if (expected_status_q.size() == 0) begin
				$error("status word %h with no operation pending", m_tdata);
				mismatches++;
			end else begin
				want = expected_status_q.pop_front();
				if (got.ok !== want.ok) begin
					$error("ok: expected %0d, got %0d", want.ok, got.ok);
					mismatches++;
				end
				if (got.count !== want.count) begin
					$error("count: expected %0d, got %0d", want.count, got.count);
					mismatches++;
				end
				if (got.full_res !== want.full_res) begin
					$error("full_res: expected %0d, got %0d", want.full_res, got.full_res);
					mismatches++;
				end
				if (got.empty_res !== want.empty_res) begin
					$error("empty_res: expected %0d, got %0d", want.empty_res, got.empty_res);
					mismatches++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// every operation on a freshly reset, empty list fails
	task automatic test_empty_list();
		send_word(KIND_DELETE, '0, '0, 8'h00);
		send_word(KIND_CHANGE, KEY_NEG1, 32'd5, 8'h00);
		send_word(KIND_UNUSED, '0, '0, 8'h00);
	endtask

	// edge keys, duplicates, misses, and keys hidden by a broken order
	task automatic test_edge_keys();
		send_word(KIND_INSERT, '0, '0, 8'h00);
		send_word(KIND_DELETE, 32'd100, '0, 8'h00);       // beyond the tail
		send_word(KIND_INSERT, KEY_MIN, KEY_MAX, 8'hFF);
		send_word(KIND_INSERT, KEY_MAX, KEY_MIN, 8'h5A);
		send_word(KIND_INSERT, KEY_NEG1, '0, 8'hA5);
		send_word(KIND_INSERT, '0, '0, 8'h11);            // duplicate
		send_word(KIND_INSERT, KEY_MAX, '0, 8'h22);       // duplicate at the tail
		send_word(KIND_DELETE, 32'd7, '0, 8'h00);         // absent, mid-list
		send_word(KIND_CHANGE, KEY_NEG1, 32'd1000, 8'h00); // breaks the order
		send_word(KIND_DELETE, '0, '0, 8'h00);            // now hidden behind 1000
		send_word(KIND_INSERT, 32'd500, '0, 8'h33);
		send_word(KIND_CHANGE, 32'd500, KEY_MAX, 8'h00);  // duplicate by change
		send_word(KIND_CHANGE, 32'd12345, '0, 8'h00);     // absent
		send_word(KIND_UNUSED, KEY_MAX, KEY_MAX, 8'hFF);
		send_word(KIND_DELETE, KEY_MIN, '0, 8'h00);       // head
		send_word(KIND_DELETE, 32'd1000, '0, 8'h00);
		send_word(KIND_DELETE, KEY_MAX, '0, 8'h00);
		send_word(KIND_DELETE, '0, '0, 8'h00);
		send_word(KIND_DELETE, KEY_MAX, '0, 8'h00);
		send_word(KIND_DELETE, KEY_MAX, '0, 8'h00);
	endtask

	// sweeps of fill toward full and drain toward empty, with random content
	task automatic test_fill_drain_traffic(input int words, input int src_pct,
			input int snk_pct);
		logic             fill_mode;
		int               pick;
		logic [KIND_W-1:0] kind;
		logic [KEY_W-1:0]  key;
		logic [KEY_W-1:0]  nkey;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		fill_mode    = 1'b1;
		for (int i = 0; i < words; i++) begin
			// linger at full a little so inserts into a full pool get tried
			if (fill_mode && records == POOL && $urandom_range(99) < 30)
				fill_mode = 1'b0;
			else if (!fill_mode && records == 0)
				fill_mode = 1'b1;
			refresh_live_keys();
			pick = $urandom_range(99);
			if (pick < 2)
				kind = KIND_UNUSED;
			else if (pick < 10)
				kind = KIND_CHANGE;
			else if (fill_mode)
				kind = (pick < 78) ? KIND_INSERT : KIND_DELETE;
			else
				kind = (pick < 32) ? KIND_INSERT : KIND_DELETE;
			// aim deletes and changes at linked keys; the head always matches
			if (kind == KIND_INSERT || live_keys.size() == 0 || $urandom_range(99) < 25)
				key = random_key();
			else if ($urandom_range(1) == 0)
				key = live_keys[0];
			else
				key = live_keys[$urandom_range(live_keys.size() - 1)];
			if (live_keys.size() != 0 && $urandom_range(99) < 20)
				nkey = live_keys[$urandom_range(live_keys.size() - 1)];
			else
				nkey = random_key();
			send_word(kind, key, nkey, 8'($urandom_range(255)));
		end
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------
	initial begin
		clear_pool_model();
		src_idle_pct = 20;
		snk_idle_pct = 83;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_edge_keys();
		test_fill_drain_traffic(PHASE_WORDS, 20, 83);
		test_fill_drain_traffic(PHASE_WORDS, 83, 20);
		test_fill_drain_traffic(PHASE_WORDS, 0, 0);

		// drop valid, collect the outstanding status words, then let the row settle
		s_tvalid <= 1'b0;
		while (expected_status_q.size() != 0)
			@(posedge clk);
		repeat (POOL + 8) @(posedge clk);

		$display("Ran %0d inserts, %0d deletes, %0d changes, %0d unused-kind words; %0d succeeded.",
			kind_sent[KIND_INSERT], kind_sent[KIND_DELETE], kind_sent[KIND_CHANGE],
			kind_sent[KIND_UNUSED], ok_total);
		$display("Pool filled %0d times and emptied %0d times; %0d status words compared.",
			full_hits, empty_hits, words_seen);
		if (mismatches == 0) begin
			$display("** sorted_static_linked_list: PASSED **");
		end else begin
			$display("** sorted_static_linked_list: FAILED **");
		end
		$finish;
	end

	// hang guard: several times the slowest legal run
	initial begin
		#4_000_000;
		$display("** sorted_static_linked_list: FAILED **");
		$finish;
	end

endmodule
